// ===== src/tpa_pkg.sv =====
package tpa_pkg;

	// Port-level field widths
	localparam int VTX_W   = 16;
	localparam int TOTAL_W = 32;
	localparam int MODE_W  = 3;

	// Default for the handle width kept in the slots
	localparam int HANDLE_BITS_DEF = 16;

	// Configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic [APB_ADDR_W-3:0] REG_DRAW_MODE = '0;

	typedef enum logic [MODE_W-1:0] {
		MODE_POINTS     = 3'd0,
		MODE_LINES      = 3'd1,
		MODE_LINE_LOOP  = 3'd2,
		MODE_LINE_STRIP = 3'd3,
		MODE_TRIS       = 3'd4,
		MODE_STRIP      = 3'd5,
		MODE_FAN        = 3'd6
	} mode_t;

	localparam mode_t MODE_RESET = MODE_TRIS;

	typedef logic [1:0] cnt_t;

	localparam cnt_t CNT_FULL = 2'd3;
	localparam cnt_t CNT_LINE = 2'd2;
	localparam cnt_t CNT_ONE  = 2'd1;

endpackage

// ===== src/tpa_if.sv =====
interface tpa_in_if;
	import tpa_pkg::*;

	logic             valid;
	logic             ready;
	logic [VTX_W-1:0] vertex_handle;
	logic             restart;

	modport source (output valid, output vertex_handle, output restart, input ready);
	modport sink   (input valid, input vertex_handle, input restart, output ready);
endinterface

interface tpa_out_if;
	import tpa_pkg::*;

	logic               valid;
	logic               ready;
	logic               prim_valid;
	logic [VTX_W-1:0]   slot_zero;
	logic [VTX_W-1:0]   slot_one;
	logic [VTX_W-1:0]   slot_two;
	logic [VTX_W-1:0]   provoking_vertex;
	logic               mode_error;
	logic [TOTAL_W-1:0] prim_total;

	modport source (
		output valid, output prim_valid, output slot_zero, output slot_one,
		output slot_two, output provoking_vertex, output mode_error,
		output prim_total, input ready
	);
	modport sink (
		input valid, input prim_valid, input slot_zero, input slot_one,
		input slot_two, input provoking_vertex, input mode_error,
		input prim_total, output ready
	);
endinterface

// ===== src/tpa_cfg.sv =====
module tpa_cfg import tpa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output mode_t                 draw_mode
);

	mode_t mode_q;
	logic  wr_en;
	logic  hit;

	assign pready = 1'b1;
	assign hit    = (paddr[APB_ADDR_W-1:2] == REG_DRAW_MODE);
	assign wr_en  = psel && penable && pwrite && pready && hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RESET;
		end else if (wr_en) begin
			mode_q <= mode_t'(pwdata[MODE_W-1:0]);
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = APB_DATA_W'(mode_q);
		end
	end

	assign draw_mode = mode_q;

endmodule

// ===== src/tpa_core.sv =====
module tpa_core import tpa_pkg::*; #(
	parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  mode_t      draw_mode,
	tpa_in_if.sink     in_ch,
	tpa_out_if.source  out_ch
);

	// handles wider than the output fields never reach the outputs
	localparam int SLOT_W = (HANDLE_BITS < VTX_W) ? HANDLE_BITS : VTX_W;

	// input register
	logic              valid_s1;
	logic [SLOT_W-1:0] vtx_s1;
	logic              restart_s1;

	// assembly state
	cnt_t               needed_q;
	logic               parity_q;
	logic [SLOT_W-1:0]  slots_q [3];
	logic [TOTAL_W-1:0] total_q;

	// result register
	logic               valid_s2;
	logic               prim_s2;
	logic [VTX_W-1:0]   slot0_s2;
	logic [VTX_W-1:0]   slot1_s2;
	logic [VTX_W-1:0]   slot2_s2;
	logic [VTX_W-1:0]   prov_s2;
	logic               err_s2;
	logic [TOTAL_W-1:0] total_s2;

	logic               advance;
	logic               supported;
	cnt_t               cnt_init;
	cnt_t               cnt_start;
	cnt_t               cnt_eff;
	cnt_t               needed_d;
	logic               parity_start;
	logic               parity_d;
	logic               done;
	logic [SLOT_W-1:0]  slots_d [3];
	logic [TOTAL_W-1:0] total_d;

	assign advance     = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			vtx_s1     <= in_ch.vertex_handle[SLOT_W-1:0];
			restart_s1 <= in_ch.restart;
		end
	end

	always_comb begin
		unique case (draw_mode)
			MODE_TRIS, MODE_STRIP, MODE_FAN:               cnt_init = CNT_FULL;
			MODE_LINES, MODE_LINE_LOOP, MODE_LINE_STRIP:   cnt_init = CNT_LINE;
			default:                                       cnt_init = CNT_ONE;
		endcase
	end

	assign supported    = (draw_mode == MODE_TRIS) || (draw_mode == MODE_STRIP) ||
	                      (draw_mode == MODE_FAN);
	assign cnt_start    = restart_s1 ? cnt_init : needed_q;
	assign parity_start = restart_s1 ? 1'b0 : parity_q;
	assign cnt_eff      = (cnt_start == 2'd0) ? CNT_FULL : cnt_start;

	always_comb begin
		slots_d  = slots_q;
		parity_d = parity_start;
		if (supported) begin
			unique case (draw_mode)
				MODE_TRIS: begin
					slots_d[cnt_eff - CNT_ONE] = vtx_s1;
				end
				MODE_STRIP: begin
					if (cnt_eff == CNT_ONE) begin
						// parity picks which older vertex is retired, keeping winding
						if (!parity_start) begin
							slots_d[2] = slots_q[0];
							slots_d[0] = vtx_s1;
						end else begin
							slots_d[2] = slots_q[1];
							slots_d[1] = vtx_s1;
						end
						parity_d = !parity_start;
					end else if (cnt_eff == CNT_FULL) begin
						slots_d[0] = vtx_s1;
					end else begin
						slots_d[1] = vtx_s1;
					end
				end
				default: begin
					// fan: slot 2 holds the hub vertex
					if (cnt_eff == CNT_ONE) begin
						slots_d[1] = slots_q[0];
						slots_d[0] = vtx_s1;
					end else if (cnt_eff == CNT_FULL) begin
						slots_d[2] = vtx_s1;
					end else begin
						slots_d[0] = vtx_s1;
					end
				end
			endcase
		end
	end

	assign done = supported && (cnt_eff == CNT_ONE);

	always_comb begin
		if (!supported) begin
			needed_d = cnt_start;
		end else if (done) begin
			needed_d = (draw_mode == MODE_TRIS) ? CNT_FULL : CNT_ONE;
		end else begin
			needed_d = cnt_eff - CNT_ONE;
		end
	end

	assign total_d = (done && (total_q != '1)) ? total_q + TOTAL_W'(1) : total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needed_q <= CNT_FULL;
			parity_q <= 1'b0;
			slots_q  <= '{default: '0};
			total_q  <= '0;
		end else if (advance) begin
			needed_q <= needed_d;
			parity_q <= parity_d;
			slots_q  <= slots_d;
			total_q  <= total_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prim_s2  <= done;
			slot0_s2 <= done ? VTX_W'(slots_d[0]) : '0;
			slot1_s2 <= done ? VTX_W'(slots_d[1]) : '0;
			slot2_s2 <= done ? VTX_W'(slots_d[2]) : '0;
			prov_s2  <= done ? VTX_W'(vtx_s1) : '0;
			err_s2   <= !supported;
			total_s2 <= total_d;
		end
	end

	assign out_ch.valid            = valid_s2;
	assign out_ch.prim_valid       = prim_s2;
	assign out_ch.slot_zero        = slot0_s2;
	assign out_ch.slot_one         = slot1_s2;
	assign out_ch.slot_two         = slot2_s2;
	assign out_ch.provoking_vertex = prov_s2;
	assign out_ch.mode_error       = err_s2;
	assign out_ch.prim_total       = total_s2;

endmodule

// ===== src/triangle_primitive_assembly_top.sv =====
// channel   dir  transfer on        payload
// in_ch     in   valid && ready    vertex_handle, restart
// out_ch    out  valid && ready    prim_valid, slot_*, provoking_vertex, mode_error, prim_total
// apb       in   psel&penable&pwrite  draw_mode at byte 0
//
// One vertex per cycle sustained while out_ch.ready stays high; a vertex passes the input
// register, then the slot update, then the result register.
// arst_n clears the handshake state, slots, countdown (3), parity and count;
// draw_mode resets to triangles.
// A stalled result holds in the result register while one more vertex waits
// in the input register; in_ch.ready drops only when both are occupied.
module triangle_primitive_assembly_top import tpa_pkg::*; #(
	parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	tpa_in_if.sink                in_ch,
	tpa_out_if.source             out_ch
);

	mode_t draw_mode;

	tpa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.draw_mode (draw_mode)
	);

	tpa_core #(
		.HANDLE_BITS (HANDLE_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.draw_mode (draw_mode),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

endmodule

// ===== tb/triangle_primitive_assembly_top_test.sv =====
`timescale 1ns / 1ps

module triangle_primitive_assembly_top_test;
	import tpa_pkg::*;

	localparam int CLK_HALF = 4;
	localparam int CYCLE_LIMIT = 400000;
	localparam int OUT_HOLD_CYCLES = 200;
	// selector with no named mode, treated like points
	localparam logic [MODE_W-1:0] MODE_SPARE_SEL = 3'd7;

	typedef struct {
		logic               prim_valid;
		logic [VTX_W-1:0]   slot_zero;
		logic [VTX_W-1:0]   slot_one;
		logic [VTX_W-1:0]   slot_two;
		logic [VTX_W-1:0]   provoking_vertex;
		logic               mode_error;
		logic [TOTAL_W-1:0] prim_total;
	} prim_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	tpa_in_if  in_ch ();
	tpa_out_if out_ch ();

	triangle_primitive_assembly_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	// assembler state as the testbench tracks it
	logic [MODE_W-1:0]  draw_sel = MODE_RESET;
	cnt_t               countdown = CNT_FULL;
	logic               parity = 1'b0;
	logic [VTX_W-1:0]   vtx_slot [3] = '{default: '0};
	logic [TOTAL_W-1:0] tri_count = '0;

	prim_result_t pending_prims [$];
	int           errors = 0;
	int           cycles = 0;
	bit           in_gaps = 1'b1;
	bit           out_gaps = 1'b1;
	bit           out_hold_req = 1'b0;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	function automatic prim_result_t assemble_vertex(logic [VTX_W-1:0] v, logic rs);
		prim_result_t r;
		cnt_t         c;
		logic         supported;
		r = '{default: '0};
		supported = (draw_sel == MODE_TRIS) || (draw_sel == MODE_STRIP) ||
			(draw_sel == MODE_FAN);
		if (rs) begin
			parity = 1'b0;
			if (supported)
				countdown = CNT_FULL;
			else if (draw_sel == MODE_LINES || draw_sel == MODE_LINE_LOOP ||
					draw_sel == MODE_LINE_STRIP)
				countdown = CNT_LINE;
			else
				countdown = CNT_ONE;
		end
		if (supported) begin
			c = (countdown == '0) ? CNT_FULL : countdown;
			case (draw_sel)
				MODE_TRIS: begin
					vtx_slot[c - 1] = v;
				end
				MODE_STRIP: begin
					if (c == CNT_ONE) begin
						// alternate which slot is replaced to keep winding
						if (!parity) begin
							vtx_slot[2] = vtx_slot[0];
							vtx_slot[0] = v;
						end else begin
							vtx_slot[2] = vtx_slot[1];
							vtx_slot[1] = v;
						end
						parity = ~parity;
					end else if (c == CNT_FULL) begin
						vtx_slot[0] = v;
					end else begin
						vtx_slot[1] = v;
					end
				end
				default: begin
					if (c == CNT_ONE) begin
						vtx_slot[1] = vtx_slot[0];
						vtx_slot[0] = v;
					end else if (c == CNT_FULL) begin
						vtx_slot[2] = v;
					end else begin
						vtx_slot[0] = v;
					end
				end
			endcase
			c = c - 1'b1;
			if (c == '0) begin
				c = (draw_sel == MODE_TRIS) ? CNT_FULL : CNT_ONE;
				r.prim_valid = 1'b1;
				r.slot_zero = vtx_slot[0];
				r.slot_one = vtx_slot[1];
				r.slot_two = vtx_slot[2];
				r.provoking_vertex = v;
				if (tri_count != '1)
					tri_count = tri_count + 1'b1;
			end
			countdown = c;
		end
		r.mode_error = !supported;
		r.prim_total = tri_count;
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		prim_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_prims.size() == 0) begin
				$error("result transfer with nothing outstanding");
				errors++;
			end else begin
				want = pending_prims.pop_front();
				check_field("prim_valid", 32'(want.prim_valid), 32'(out_ch.prim_valid));
				check_field("slot_zero", 32'(want.slot_zero), 32'(out_ch.slot_zero));
				check_field("slot_one", 32'(want.slot_one), 32'(out_ch.slot_one));
				check_field("slot_two", 32'(want.slot_two), 32'(out_ch.slot_two));
				check_field("provoking_vertex", 32'(want.provoking_vertex),
					32'(out_ch.provoking_vertex));
				check_field("mode_error", 32'(want.mode_error), 32'(out_ch.mode_error));
				check_field("prim_total", want.prim_total, out_ch.prim_total);
			end
		end
	end

	// result receiver, with random stalls and an on-demand long hold
	initial begin
		int hold_left;
		hold_left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_hold_req) begin
				out_hold_req = 1'b0;
				hold_left = OUT_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= !(out_gaps && $urandom_range(0, 99) < 7);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_vertex(logic [VTX_W-1:0] handle, logic rs);
		if (in_gaps && $urandom_range(0, 99) < 7) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.vertex_handle <= handle;
		in_ch.restart <= rs;
		do @(posedge clk); while (!in_ch.ready);
		pending_prims.push_back(assemble_vertex(handle, rs));
	endtask

	// change draw mode once the pipeline has drained, then read it back
	task automatic write_mode(logic [MODE_W-1:0] m);
		in_ch.valid <= 1'b0;
		while (pending_prims.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_DRAW_MODE, 2'b00};
		pwdata <= {(APB_DATA_W - MODE_W)'($urandom), m};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		draw_sel = m;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== APB_DATA_W'(m)) begin
			$error("draw_mode readback: expected %0h, got %0h", m, prdata);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [VTX_W-1:0] pick_handle();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return '1;
			default: return VTX_W'($urandom);
		endcase
	endfunction

	// draws of random length in the current mode, a few stray restarts mixed in
	task automatic run_draws(int count, bit restart_first);
		int left;
		int len;
		bit first;
		left = count;
		first = 1'b1;
		while (left > 0) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 14);
			for (int k = 0; k < len && left > 0; k++) begin
				if (k == 0)
					send_vertex(pick_handle(), first ? restart_first : 1'b1);
				else
					send_vertex(pick_handle(), $urandom_range(0, 99) < 3);
				left--;
			end
			first = 1'b0;
		end
	endtask

	task automatic test_triangle_list();
		write_mode(MODE_TRIS);
		send_vertex('0, 1'b1);
		send_vertex('1, 1'b0);
		send_vertex(16'h5555, 1'b0);
		send_vertex(16'hAAAA, 1'b1);
		send_vertex(16'h0001, 1'b0);
		// restart in the middle of a triangle drops the partial one
		send_vertex(16'h8000, 1'b1);
		send_vertex(16'h0002, 1'b0);
		send_vertex(16'h0003, 1'b0);
	endtask

	task automatic test_strip();
		write_mode(MODE_STRIP);
		for (int k = 0; k < 6; k++)
			send_vertex(VTX_W'(16'h0010 + k), k == 0);
	endtask

	task automatic test_fan();
		write_mode(MODE_FAN);
		for (int k = 0; k < 4; k++)
			send_vertex(VTX_W'(16'h0020 + k), k == 0);
		send_vertex('1, 1'b0);
	endtask

	task automatic test_unsupported_modes();
		write_mode(MODE_POINTS);
		send_vertex(pick_handle(), 1'b1);
		write_mode(MODE_LINES);
		send_vertex(pick_handle(), 1'b1);
		write_mode(MODE_LINE_LOOP);
		send_vertex(pick_handle(), 1'b0);
		write_mode(MODE_LINE_STRIP);
		send_vertex(pick_handle(), 1'b1);
		write_mode(MODE_SPARE_SEL);
		send_vertex(pick_handle(), 1'b1);
		// no restart: the countdown left by the last restart carries over
		write_mode(MODE_TRIS);
		send_vertex(16'h0030, 1'b0);
		send_vertex(16'h0031, 1'b0);
	endtask

	task automatic test_random_draws();
		logic [MODE_W-1:0] m;
		for (int p = 0; p < 13; p++) begin
			if (p == 0)
				m = MODE_POINTS;
			else if (p == 1)
				m = MODE_FAN;
			else if ($urandom_range(0, 99) < 80)
				m = MODE_W'(MODE_TRIS + $urandom_range(0, 2));
			else
				m = MODE_W'($urandom_range(0, 3));
			write_mode(m);
			run_draws(70, $urandom_range(0, 99) < 70);
		end
	endtask

	task automatic test_steady_stream();
		write_mode(MODE_STRIP);
		in_gaps = 1'b0;
		out_gaps = 1'b0;
		run_draws(200, 1'b1);
		in_gaps = 1'b1;
		out_gaps = 1'b1;
	endtask

	task automatic test_backpressure();
		write_mode(MODE_FAN);
		out_hold_req = 1'b1;
		run_draws(60, 1'b1);
	endtask

	initial begin
		arst_n = 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.vertex_handle <= '0;
		in_ch.restart <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_triangle_list();
		test_strip();
		test_fan();
		test_unsupported_modes();
		test_random_draws();
		test_steady_stream();
		test_backpressure();

		in_ch.valid <= 1'b0;
		while (pending_prims.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
src/tpa_pkg.sv
src/tpa_if.sv
src/tpa_cfg.sv
src/tpa_core.sv
src/triangle_primitive_assembly_top.sv
tb/triangle_primitive_assembly_top_test.sv
